// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AIS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// next-cycle implication, disabled during reset
`define AIS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`endif

// ===== hw/rtl/ais_pkg.sv =====
// types, constants and character helpers for the ascii integer scanner
package ais_pkg;

   localparam int ACC_WIDTH_DEFAULT = 64;
   localparam int CHAR_WIDTH        = 8;
   localparam int VALUE_WIDTH       = 64;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KIND     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GROUPING = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIZE     = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUPPRESS = 2'd3;

   // conversion kinds
   localparam logic [2:0] KIND_SDEC = 3'd0;
   localparam logic [2:0] KIND_AUTO = 3'd1;
   localparam logic [2:0] KIND_OCT  = 3'd2;
   localparam logic [2:0] KIND_UDEC = 3'd3;
   localparam logic [2:0] KIND_HEX  = 3'd4;

   // store sizes
   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_32 = 2'd2;
   localparam logic [1:0] SIZE_64 = 2'd3;

   // characters
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_F_UP  = 8'h46;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_F_LO  = 8'h66;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] TEN      = 8'd10;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_in;
      logic                  end_of_input;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   failed;
      logic                   stored;
      logic                   ended_by_eof;
      logic [CHAR_WIDTH-1:0]  terminator;
   } rsp_type;

   typedef struct packed {
      logic [2:0] conversion_kind;
      logic       allow_grouping;
      logic [1:0] store_size;
      logic       suppress_store;
   } cfg_type;

   function automatic logic is_space(input logic [7:0] c);
      return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_A_LO) && (c <= CH_F_LO)) ||
             ((c >= CH_A_UP) && (c <= CH_F_UP));
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         d = c - CH_ZERO;
      end else if ((c >= CH_A_LO) && (c <= CH_F_LO)) begin
         d = c - CH_A_LO + TEN;
      end else begin
         d = c - CH_A_UP + TEN;
      end
      return d[3:0];
   endfunction

endpackage

// ===== hw/rtl/ais_csr.sv =====
// configuration registers of the scanner
module ais_csr
   import ais_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KIND:     cfg_in.conversion_kind = csr_wdata;
            CSR_GROUPING: cfg_in.allow_grouping  = csr_wdata[0];
            CSR_SIZE:     cfg_in.store_size      = csr_wdata[1:0];
            CSR_SUPPRESS: cfg_in.suppress_store  = csr_wdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conversion_kind <= KIND_SDEC;
         cfg_ff.allow_grouping  <= 1'b0;
         cfg_ff.store_size      <= SIZE_32;
         cfg_ff.suppress_store  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/ais_core.sv =====
// scan state machine, accumulator and result formatting
module ais_core
   import ais_pkg::*;
#(
   parameter int ACC_WIDTH = ACC_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    step_en,
   input  req_type item,
   output logic    res_valid,
   output rsp_type res_data
);

`include "assert_macros.svh"

   typedef enum logic [6:0] {
      PH_SKIP      = 7'b0000001,
      PH_AUTO      = 7'b0000010,
      PH_AUTO_ZERO = 7'b0000100,
      PH_DEC       = 7'b0001000,
      PH_OCT       = 7'b0010000,
      PH_HEX       = 7'b0100000,
      PH_HEX_PRE   = 7'b1000000
   } phase_type;

   phase_type phase_ff, phase_in, eff_phase;
   logic [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic neg_ff, neg_in;
   logic any_ff, any_in;
   logic do_finish, done;

   logic [7:0] c;
   logic is_dec, is_oct, is_x, is_zero, is_minus;
   logic [3:0] dig;
   logic [ACC_WIDTH-1:0] acc_x8, acc_x10, acc_x16, signed_val;
   logic [VALUE_WIDTH-1:0] ext_val, sized_val;
   logic fail_clean, state_clear;

   assign c        = item.char_in;
   assign is_dec   = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_oct   = (c >= CH_ZERO) && (c <= CH_SEVEN);
   assign is_x     = (c == CH_X_LO) || (c == CH_X_UP);
   assign is_zero  = (c == CH_ZERO);
   assign is_minus = (c == CH_MINUS);
   assign dig      = hex_value(c);

   // constant multiplies as shifts plus the digit add; times ten takes a second add
   assign acc_x8  = (acc_ff << 3) + ACC_WIDTH'(dig);
   assign acc_x16 = (acc_ff << 4) + ACC_WIDTH'(dig);
   assign acc_x10 = (acc_ff << 3) + (acc_ff << 1) + ACC_WIDTH'(dig);

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      any_in    = any_ff;
      do_finish = 1'b0;
      done      = 1'b0;
      eff_phase = phase_ff;
      if (item.end_of_input) begin
         do_finish = 1'b1;
      end else begin
         if (phase_ff == PH_SKIP) begin
            if (is_space(c)) begin
               done = 1'b1;
            end else begin
               unique case (cfg.conversion_kind)
                  KIND_AUTO: begin
                     if (is_minus) begin
                        neg_in   = 1'b1;
                        phase_in = PH_AUTO;
                        done     = 1'b1;
                     end else begin
                        eff_phase = PH_AUTO;
                     end
                  end
                  KIND_OCT:  eff_phase = PH_OCT;
                  KIND_UDEC: eff_phase = PH_DEC;
                  KIND_HEX: begin
                     if (is_zero) begin
                        any_in   = 1'b1;
                        phase_in = PH_HEX_PRE;
                        done     = 1'b1;
                     end else begin
                        eff_phase = PH_HEX;
                     end
                  end
                  default: begin
                     if (is_minus) begin
                        neg_in   = 1'b1;
                        phase_in = PH_DEC;
                        done     = 1'b1;
                     end else begin
                        eff_phase = PH_DEC;
                     end
                  end
               endcase
            end
         end
         if (!done) begin
            // fall-through phases resolved before the character is used
            if ((eff_phase == PH_AUTO) && !is_zero) eff_phase = PH_DEC;
            if ((eff_phase == PH_AUTO_ZERO) && is_oct) eff_phase = PH_OCT;
            if ((eff_phase == PH_HEX_PRE) && !is_x) eff_phase = PH_HEX;
            unique case (eff_phase)
               PH_AUTO: begin
                  any_in   = 1'b1;
                  phase_in = PH_AUTO_ZERO;
               end
               PH_AUTO_ZERO: begin
                  if (is_x) phase_in = PH_HEX;
                  else      do_finish = 1'b1;
               end
               PH_HEX_PRE: phase_in = PH_HEX;
               PH_OCT: begin
                  if (is_oct) begin
                     acc_in   = acc_x8;
                     any_in   = 1'b1;
                     phase_in = PH_OCT;
                  end else begin
                     do_finish = 1'b1;
                  end
               end
               PH_HEX: begin
                  if (is_hex(c)) begin
                     acc_in   = acc_x16;
                     any_in   = 1'b1;
                     phase_in = PH_HEX;
                  end else begin
                     do_finish = 1'b1;
                  end
               end
               PH_DEC: begin
                  phase_in = PH_DEC;
                  if (is_dec) begin
                     acc_in = acc_x10;
                     any_in = 1'b1;
                  end else if ((c == CH_QUOTE) && cfg.allow_grouping) begin
                     any_in = 1'b1;
                  end else begin
                     do_finish = 1'b1;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
      if (do_finish) begin
         phase_in = PH_SKIP;
         acc_in   = '0;
         neg_in   = 1'b0;
         any_in   = 1'b0;
      end
   end

   assign signed_val = neg_ff ? -acc_ff : acc_ff;
   assign ext_val    = VALUE_WIDTH'(signed_val);

   always_comb begin
      unique case (cfg.store_size)
         SIZE_8:  sized_val = ext_val & VALUE_WIDTH'(64'h0000_0000_0000_00ff);
         SIZE_16: sized_val = ext_val & VALUE_WIDTH'(64'h0000_0000_0000_ffff);
         SIZE_32: sized_val = ext_val & VALUE_WIDTH'(64'h0000_0000_ffff_ffff);
         default: sized_val = ext_val;
      endcase
   end

   assign res_valid             = step_en && do_finish;
   assign res_data.value        = any_ff ? sized_val : '0;
   assign res_data.failed       = !any_ff;
   assign res_data.stored       = any_ff && !cfg.suppress_store;
   assign res_data.ended_by_eof = item.end_of_input;
   assign res_data.terminator   = item.end_of_input ? '0 : c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         any_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         any_ff   <= any_in;
      end
   end

   assign fail_clean  = (res_data.value == '0) && !res_data.stored;
   assign state_clear = (phase_ff == PH_SKIP) && (acc_ff == '0) && !neg_ff && !any_ff;

   `AIS_ASSERT_IMP(a_fail_clean, clock, reset, res_valid && res_data.failed, fail_clean)
   `AIS_ASSERT_NXT(a_finish_resets, clock, reset, res_valid, state_clear)
   `AIS_ASSERT_IMP(a_acc_needs_digit, clock, reset, !any_ff, acc_ff == '0)

endmodule

// ===== hw/rtl/ascii_integer_scanner_unit.sv =====
// a transaction is accepted into the input register and scanned when the output register is
// free or draining; a number's closing character loads its result into the output register
// throughput: one character per cycle while the output register is free or draining
// a waiting result stalls scanning; the input register then holds one character, drops ready
// reset is synchronous: scan state returns to whitespace skip, configuration to its defaults
module ascii_integer_scanner_unit
   import ais_pkg::*;
#(
   parameter int ACC_WIDTH = ACC_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type cfg;
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    step_go;
   logic    res_valid;
   rsp_type res_data;

   ais_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ais_core #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step_en   (step_go),
      .item      (in_data_ff),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // scan the held character when the output register is free or draining
   assign step_go      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || step_go;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !step_go);
   assign rsp_valid_in = step_go ? res_valid : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the ascii integer scanner unit
`timescale 1ns / 1ps

module testbench;
   import ais_pkg::*;

   typedef enum logic [2:0] {
      SCAN_SKIP, SCAN_AUTO, SCAN_AUTO_ZERO, SCAN_DEC, SCAN_OCT, SCAN_HEX, SCAN_HEX_PRE
   } scan_phase_type;

   // predicts each number that the transactions close and checks the results in order
   class number_scoreboard;
      logic [2:0]     kind;
      logic           grouping;
      logic [1:0]     size;
      logic           suppress;
      scan_phase_type phase;
      logic [63:0]    acc;
      bit             neg;
      bit             consumed;
      rsp_type        expected_numbers[$];
      int             mismatches;

      function void reset_model();
         kind = KIND_SDEC;
         grouping = 1'b0;
         size = SIZE_32;
         suppress = 1'b0;
         phase = SCAN_SKIP;
         acc = '0;
         neg = 0;
         consumed = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx,
                              logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_KIND:     kind = data;
            CSR_GROUPING: grouping = data[0];
            CSR_SIZE:     size = data[1:0];
            CSR_SUPPRESS: suppress = data[0];
            default: ;
         endcase
      endfunction

      function int hex_weight(logic [7:0] c);
         if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
         if (c >= CH_A_LO && c <= CH_F_LO) return int'(c - CH_A_LO) + 10;
         if (c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + 10;
         return -1;
      endfunction

      function void add_digit(int base, int digit);
         acc = acc * base + digit;
         consumed = 1;
      endfunction

      function void close_number(logic [7:0] term, bit eof);
         rsp_type     e;
         logic [63:0] v;
         v = neg ? (64'd0 - acc) : acc;
         case (size)
            SIZE_8:  v = {56'd0, v[7:0]};
            SIZE_16: v = {48'd0, v[15:0]};
            SIZE_32: v = {32'd0, v[31:0]};
            default: ;
         endcase
         e.value = consumed ? v : '0;
         e.failed = !consumed;
         e.stored = consumed && !suppress;
         e.ended_by_eof = eof;
         e.terminator = eof ? 8'h00 : term;
         expected_numbers.push_back(e);
         phase = SCAN_SKIP;
         acc = '0;
         neg = 0;
         consumed = 0;
      endfunction

      // one character inside a number; a phase change may hand it on to the next phase
      function void scan_body(logic [7:0] c);
         int d;
         bit done;
         done = 0;
         while (!done) begin
            done = 1;
            case (phase)
               SCAN_AUTO: begin
                  if (c == CH_ZERO) begin
                     consumed = 1;
                     phase = SCAN_AUTO_ZERO;
                  end else begin
                     phase = SCAN_DEC;
                     done = 0;
                  end
               end
               SCAN_AUTO_ZERO: begin
                  if (c == CH_X_LO || c == CH_X_UP) begin
                     phase = SCAN_HEX;
                  end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                     phase = SCAN_OCT;
                     done = 0;
                  end else begin
                     close_number(c, 0);
                  end
               end
               SCAN_HEX_PRE: begin
                  if (c == CH_X_LO || c == CH_X_UP) begin
                     phase = SCAN_HEX;
                  end else begin
                     phase = SCAN_HEX;
                     done = 0;
                  end
               end
               SCAN_OCT: begin
                  if (c >= CH_ZERO && c <= CH_SEVEN) add_digit(8, int'(c - CH_ZERO));
                  else close_number(c, 0);
               end
               SCAN_HEX: begin
                  d = hex_weight(c);
                  if (d >= 0) add_digit(16, d);
                  else close_number(c, 0);
               end
               default: begin
                  if (c >= CH_ZERO && c <= CH_NINE) add_digit(10, int'(c - CH_ZERO));
                  else if (c == CH_QUOTE && grouping) consumed = 1;
                  else close_number(c, 0);
               end
            endcase
         end
      endfunction

      function void note_request(req_type r);
         logic [7:0] c;
         c = r.char_in;
         if (r.end_of_input) begin
            close_number(8'h00, 1);
            return;
         end
         if (phase != SCAN_SKIP) begin
            scan_body(c);
            return;
         end
         if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) return;
         case (kind)
            KIND_AUTO: begin
               phase = SCAN_AUTO;
               if (c == CH_MINUS) begin
                  neg = 1;
                  return;
               end
            end
            KIND_OCT:  phase = SCAN_OCT;
            KIND_UDEC: phase = SCAN_DEC;
            KIND_HEX: begin
               if (c == CH_ZERO) begin
                  consumed = 1;
                  phase = SCAN_HEX_PRE;
                  return;
               end
               phase = SCAN_HEX;
            end
            default: begin
               phase = SCAN_DEC;
               if (c == CH_MINUS) begin
                  neg = 1;
                  return;
               end
            end
         endcase
         scan_body(c);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_response(rsp_type got);
         rsp_type e;
         if (expected_numbers.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, value %h", got.value));
            return;
         end
         e = expected_numbers.pop_front();
         if (got.value !== e.value)
            report_mismatch($sformatf("value %h, expected %h", got.value, e.value));
         if (got.failed !== e.failed)
            report_mismatch($sformatf("failed %b, expected %b", got.failed, e.failed));
         if (got.stored !== e.stored)
            report_mismatch($sformatf("stored %b, expected %b", got.stored, e.stored));
         if (got.ended_by_eof !== e.ended_by_eof)
            report_mismatch($sformatf("ended_by_eof %b, expected %b",
                                      got.ended_by_eof, e.ended_by_eof));
         if (got.terminator !== e.terminator)
            report_mismatch($sformatf("terminator %h, expected %h",
                                      got.terminator, e.terminator));
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_type                    req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_type                    rsp_data;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   number_scoreboard sb = new();
   bit               quiet = 0;
   bit               hold_request = 0;
   int               chars_sent = 0;

   ascii_integer_scanner_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input req_type r);
      req_valid = 1'b0;
      while (!quiet && $urandom_range(99) < 34) @(negedge clock);
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      chars_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_char(input logic [7:0] c);
      req_type r;
      r.char_in = c;
      r.end_of_input = 1'b0;
      send_item(r);
   endtask

   task automatic send_eof();
      req_type r;
      // char_in is don't-care here, so let it toggle
      r.char_in = 8'($urandom_range(255));
      r.end_of_input = 1'b1;
      send_item(r);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic wait_for_idle();
      while (sb.expected_numbers.size() != 0) @(posedge clock);
      // a trailing digit may still be in flight without a result
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                   input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic apply_settings(input logic [2:0] kind, input logic grp,
                                 input logic [1:0] size, input logic sup);
      wait_for_idle();
      program_register(CSR_KIND, kind);
      program_register(CSR_GROUPING, {2'b00, grp});
      program_register(CSR_SIZE, {1'b0, size});
      program_register(CSR_SUPPRESS, {2'b00, sup});
   endtask

   function automatic logic [7:0] pick_digit(int base);
      int r;
      r = $urandom_range(base - 1);
      if (r < 10) return 8'(CH_ZERO + r);
      return 8'(($urandom_range(1) ? CH_A_LO : CH_A_UP) + (r - 10));
   endfunction

   function automatic logic [7:0] pick_space();
      int r;
      r = $urandom_range(6);
      return (r == 6) ? CH_SPACE : 8'(CH_TAB + r);
   endfunction

   // a number for the current kind, with random content; the digit run may be empty
   task automatic send_number();
      int         base;
      int         ndig;
      logic [7:0] t;
      repeat ($urandom_range(2)) send_char(pick_space());
      base = 10;
      if (sb.kind != KIND_OCT && sb.kind != KIND_UDEC && sb.kind != KIND_HEX &&
          $urandom_range(3) == 0)
         send_char(CH_MINUS);
      if (sb.kind == KIND_AUTO) begin
         case ($urandom_range(2))
            0: begin
               send_char(CH_ZERO);
               send_char($urandom_range(1) ? CH_X_LO : CH_X_UP);
               base = 16;
            end
            1: begin
               send_char(CH_ZERO);
               base = 8;
            end
            default: send_char(8'(CH_ZERO + $urandom_range(1, 9)));
         endcase
      end else if (sb.kind == KIND_OCT) begin
         base = 8;
      end else if (sb.kind == KIND_HEX) begin
         base = 16;
         if ($urandom_range(1)) begin
            send_char(CH_ZERO);
            send_char($urandom_range(1) ? CH_X_LO : CH_X_UP);
         end
      end
      // now and then a long run of digits to wrap the accumulator
      ndig = ($urandom_range(9) == 0) ? $urandom_range(16, 24) : $urandom_range(0, 6);
      for (int i = 0; i < ndig; i++) begin
         if (base == 10 && sb.grouping && $urandom_range(5) == 0) send_char(CH_QUOTE);
         send_char(pick_digit(base));
      end
      if ($urandom_range(9) == 0) begin
         send_eof();
      end else begin
         t = $urandom_range(1) ? CH_SPACE : 8'($urandom_range(255));
         send_char(t);
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(255)));
      if ($urandom_range(3) == 0) send_eof();
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      int hold;
      bit hold_taken;
      hold = 0;
      hold_taken = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold = 400;
            hold_taken = 1;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = quiet || ($urandom_range(99) >= 34);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   initial begin
      #10_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      int phase_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_KIND;
      csr_wdata = '0;
      sb.reset_model();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: sign, whitespace then end, plus is not a sign
      send_text("-42 ");
      send_char(CH_SPACE);
      send_eof();
      send_text("+");
      apply_settings(KIND_SDEC, 1'b1, SIZE_64, 1'b0);
      send_text("-9");
      send_eof();
      // grouping, and a number of apostrophes only
      send_text("1'2 ");
      send_char(CH_QUOTE);
      send_eof();
      // bare hex prefix and octal ended by the top character code
      apply_settings(KIND_AUTO, 1'b0, SIZE_8, 1'b0);
      send_text("0xg07");
      send_char(8'hff);
      apply_settings(KIND_HEX, 1'b0, SIZE_16, 1'b1);
      send_text("0Xf");
      send_eof();
      apply_settings(KIND_OCT, 1'b0, SIZE_16, 1'b0);
      send_char(8'h00);
      // unused kind acts as signed decimal; kind changes mid-number keep the base
      apply_settings(3'd7, 1'b0, SIZE_32, 1'b0);
      send_text("-1");
      apply_settings(KIND_HEX, 1'b1, SIZE_32, 1'b0);
      send_eof();

      for (int p = 0; p < 16; p++) begin
         if (p == 0) apply_settings(KIND_SDEC, 1'b0, SIZE_8, 1'b0);
         else if (p == 1) apply_settings(3'd7, 1'b1, SIZE_64, 1'b1);
         else apply_settings(3'($urandom_range(7)), 1'($urandom_range(1)),
                             2'($urandom_range(3)), ($urandom_range(3) == 0));
         quiet = (p == 5);
         if (p == 9) hold_request = 1;
         phase_start = chars_sent;
         while (chars_sent - phase_start < 42) begin
            if ($urandom_range(99) < 15) send_noise();
            else send_number();
         end
      end
      quiet = 0;

      while (sb.expected_numbers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_numbers.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ais_pkg.sv
hw/rtl/ais_csr.sv
hw/rtl/ais_core.sv
hw/rtl/ascii_integer_scanner_unit.sv
verif/testbench.sv
